// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/lpfr_pkg.sv =====
// ----------------------------------------------------------------------------
// lpfr_pkg
// Types and constants of the length-prefixed frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package lpfr_pkg;

    localparam logic [15:0] FRAME_LENGTH_RST  = 16'd40960;
    localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd5000;
    localparam logic [16:0] IDLE_MAX          = 17'h1FFFF;

    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_PAYLOAD = 2'd1;
    localparam logic [1:0] EV_REJECT  = 2'd2;
    localparam logic [1:0] EV_TIMEOUT = 2'd3;

    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic REG_FRAME_LENGTH  = 1'b0;
    localparam logic REG_TIMEOUT_TICKS = 1'b1;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
    } t_item;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [7:0]  payload_byte;
        logic [15:0] byte_index;
        logic        last;
    } t_res;

    typedef struct packed {
        logic       is_tick;
        logic [7:0] data;
    } t_op;

    typedef struct packed {
        logic [15:0] frame_length;
        logic [15:0] timeout_ticks;
    } t_cfg;

endpackage

`default_nettype wire

// ===== rtl/length_prefixed_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_frame_receiver
// Length-prefixed frame receiver with idle timeout.
// ----------------------------------------------------------------------------
// Input channel (i_valid, o_stall, i_item): each item is a received byte
// (command 0) or a one millisecond tick (command 1), taken at an edge with
// i_valid high and o_stall low. Every item yields exactly one result.
// Output channel (o_valid, i_stall, o_res): a result reports no event,
// a payload byte with its index and last flag, a rejected header, or a
// timeout. A result holds while i_stall is high.
// From the accepting edge to o_valid, the item passes the input register,
// the four-entry queue and the result register. One item is taken every
// cycle while the output is not stalled; the frame engine settles one item
// per cycle. Under a stall the pipeline holds six items (input register,
// queue, result register) and o_stall rises once all six are taken.
// Reset (synchronous, active low) empties the pipeline, returns to the
// header phase, clears the idle tick count and loads the default frame
// length and timeout. The user must set registers over the APB port
// only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefixed_frame_receiver
    import lpfr_pkg::*;
#(
    parameter int HEADER_BYTES = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire t_item       i_item,
    output logic             o_valid,
    input  wire logic        i_stall,
    output t_res             o_res,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    t_cfg r_cfg;
    logic cfg_wr;
    logic push;
    logic full;
    logic pop;
    logic q_valid;
    t_op  f_op;
    t_op  q_op;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_length  <= FRAME_LENGTH_RST;
            r_cfg.timeout_ticks <= TIMEOUT_TICKS_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_FRAME_LENGTH:  r_cfg.frame_length  <= pwdata[15:0];
                REG_TIMEOUT_TICKS: r_cfg.timeout_ticks <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_FRAME_LENGTH:  prdata = {16'd0, r_cfg.frame_length};
            REG_TIMEOUT_TICKS: prdata = {16'd0, r_cfg.timeout_ticks};
            default:           prdata = '0;
        endcase
    end

    lpfr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_push  (push),
        .o_op    (f_op),
        .i_full  (full)
    );

    lpfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (f_op),
        .o_full  (full),
        .o_valid (q_valid),
        .o_op    (q_op),
        .i_pop   (pop)
    );

    lpfr_back #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_op      (q_op),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .o_res     (o_res),
        .i_stall   (i_stall)
    );

endmodule

`default_nettype wire

// ===== rtl/lpfr_front.sv =====
// ----------------------------------------------------------------------------
// lpfr_front
// Input stage: accepts items, classifies them as tick or data and holds
// them until the queue takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfr_front
    import lpfr_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_stall,
    input  wire t_item i_item,
    output logic       o_push,
    output t_op        o_op,
    input  wire logic  i_full
);

    logic r_valid;
    logic n_valid;
    t_op  r_op;
    logic accept;

    assign o_push  = r_valid && !i_full;
    assign o_stall = r_valid && i_full;
    assign accept  = i_valid && !o_stall;
    assign o_op    = r_op;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op.is_tick <= (i_item.command == CMD_TICK);
            r_op.data    <= i_item.data_byte;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lpfr_queue.sv =====
// ----------------------------------------------------------------------------
// lpfr_queue
// Short FIFO between the input stage and the frame engine.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfr_queue
    import lpfr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_op  i_op,
    output logic      o_full,
    output logic      o_valid,
    output t_op       o_op,
    input  wire logic i_pop
);

    t_op            r_mem [QDEPTH];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QAW:0]   r_count;
    logic [QAW-1:0] n_wr;
    logic [QAW-1:0] n_rd;
    logic [QAW:0]   n_count;

    assign o_full  = (r_count == (QAW+1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_op;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lpfr_back.sv =====
// ----------------------------------------------------------------------------
// lpfr_back
// Frame engine: header assembly, payload indexing, idle timeout and the
// registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfr_back
    import lpfr_pkg::*;
#(
    parameter int HEADER_BYTES = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire logic i_q_valid,
    input  wire t_op  i_op,
    output logic      o_pop,
    output logic      o_valid,
    output t_res      o_res,
    input  wire logic i_stall
);

    localparam int HW = 8 * HEADER_BYTES;

    logic          r_valid;
    logic          n_valid;
    t_res          r_res;
    t_res          n_res;
    logic          r_in_payload;
    logic          n_in_payload;
    logic [15:0]   r_pos;
    logic [15:0]   n_pos;
    logic [HW-1:0] r_shift;
    logic [HW-1:0] n_shift;
    logic [16:0]   r_idle;
    logic [16:0]   n_idle;

    logic [HW-1:0] shift_cat;
    logic [15:0]   pos_inc;
    logic [16:0]   idle_inc;

    assign o_pop   = i_q_valid && (!r_valid || !i_stall);
    assign o_valid = r_valid;
    assign o_res   = r_res;

    assign shift_cat = HW'({r_shift, i_op.data});
    assign pos_inc   = r_pos + 16'd1;
    assign idle_inc  = (r_idle != IDLE_MAX) ? (r_idle + 17'd1) : r_idle;

    always_comb begin
        n_in_payload = r_in_payload;
        n_pos        = r_pos;
        n_shift      = r_shift;
        n_idle       = r_idle;
        n_res        = r_res;
        n_valid      = r_valid;
        if (o_pop) begin
            n_valid = 1'b1;
            n_res   = '0;
            if (i_op.is_tick) begin
                n_idle = idle_inc;
                if (idle_inc > {1'b0, i_cfg.timeout_ticks}) begin
                    n_res.event_res = EV_TIMEOUT;
                    n_in_payload    = 1'b0;
                    n_pos           = '0;
                    n_shift         = '0;
                    n_idle          = '0;
                end
            end else if (!r_in_payload) begin
                if (pos_inc == 16'(HEADER_BYTES)) begin
                    n_pos   = '0;
                    n_shift = '0;
                    if (32'(shift_cat) == {16'd0, i_cfg.frame_length}) begin
                        n_in_payload = 1'b1;
                    end else begin
                        n_res.event_res = EV_REJECT;
                    end
                end else begin
                    n_pos   = pos_inc;
                    n_shift = shift_cat;
                end
            end else begin
                n_res.event_res    = EV_PAYLOAD;
                n_res.payload_byte = i_op.data;
                n_res.byte_index   = r_pos;
                if (pos_inc == i_cfg.frame_length) begin
                    n_res.last   = 1'b1;
                    n_in_payload = 1'b0;
                    n_pos        = '0;
                    n_shift      = '0;
                    n_idle       = '0;
                end else begin
                    n_pos = pos_inc;
                end
            end
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_in_payload <= 1'b0;
            r_pos        <= '0;
            r_shift      <= '0;
            r_idle       <= '0;
        end else begin
            r_valid      <= n_valid;
            r_in_payload <= n_in_payload;
            r_pos        <= n_pos;
            r_shift      <= n_shift;
            r_idle       <= n_idle;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

endmodule

`default_nettype wire

// ===== rtl/lpfr_checker.sv =====
// ----------------------------------------------------------------------------
// lpfr_checker
// Port-level checks of the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lpfr_checker
    import lpfr_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_valid,
    input wire logic i_stall,
    input wire t_res o_res
);

    `ASSERT_CLK(a_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_res), "result changed under stall")
    `ASSERT_CLK(a_quiet, i_clk, i_rst_n, o_valid && o_res.event_res != EV_PAYLOAD |-> o_res.payload_byte == 8'd0 && o_res.byte_index == 16'd0 && !o_res.last, "non-payload result carries payload fields")
    `ASSERT_CLK(a_last, i_clk, i_rst_n, o_valid && o_res.last |-> o_res.event_res == EV_PAYLOAD, "last without payload byte")
    `ASSERT_ALWAYS(a_reset, i_clk, $past(!i_rst_n) |-> !o_valid, "result valid right after reset")

endmodule

bind length_prefixed_frame_receiver lpfr_checker u_lpfr_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_res   (o_res)
);

`default_nettype wire
